// ===== design/tph_pkg.sv =====
package tph_pkg;

    // Default length of one proportioning window in milliseconds.
    localparam int unsigned WINDOW_MS_DEF = 20000;

    // Field widths fixed by the word formats.
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned TEMP_W   = 14;
    localparam int unsigned TARGET_W = 12;
    localparam int unsigned ON_OUT_W = 15;
    localparam int unsigned ERR_W    = 16;

    // Reset value of the setpoint, hundredths of a degree.
    localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd3780;

    // Error thresholds, hundredths of a degree.
    localparam logic signed [ERR_W-1:0] ERR_OFF_BAND  = 16'sd15;
    localparam logic signed [ERR_W-1:0] ERR_FULL      = 16'sd200;
    localparam logic signed [ERR_W-1:0] ERR_PROP_HIGH = 16'sd80;
    localparam logic signed [ERR_W-1:0] ERR_PROP_LOW  = 16'sd30;
    localparam logic signed [ERR_W-1:0] ERR_ZERO      = 16'sd0;

    // Linear part of the on-time curve: one entry per hundredth from 30 to 80.
    localparam int unsigned ON_TAB_N = 51;
    localparam int unsigned ON_IDX_W = 6;

    typedef int unsigned on_tab_t [ON_TAB_N];

    typedef struct packed {
        logic [TIME_W-1:0]        now_ms;
        logic signed [TEMP_W-1:0] temp_centi;
        logic                     temp_valid;
    } tph_item_t;

    typedef struct packed {
        logic      valid;
        tph_item_t item;
    } tph_stage_t;

    // On-time for each step of the linear section, in milliseconds:
    // window * (5% + 1.9% per hundredth above 0.30 degrees), truncated.
    function automatic on_tab_t build_on_tab(int unsigned window_ms);
        on_tab_t tab;
        for (int d = 0; d < ON_TAB_N; d++)
        begin
            tab[d] = (window_ms * (50 + 19 * d)) / 1000;
        end
        return tab;
    endfunction

endpackage

// ===== design/tph_if.sv =====
interface tph_in_if;
    logic                                       valid;
    logic                                       ready;
    logic [tph_pkg::TIME_W-1:0]                 now_ms;
    logic signed [tph_pkg::TEMP_W-1:0]          temp_centi;
    logic                                       temp_valid;

    modport source (output valid, now_ms, temp_centi, temp_valid, input ready);
    modport sink   (input valid, now_ms, temp_centi, temp_valid, output ready);
endinterface

interface tph_out_if;
    logic                                       valid;
    logic                                       ready;
    logic                                       heater_on;
    logic                                       full_mode;
    logic [tph_pkg::ON_OUT_W-1:0]               on_time_ms;

    modport source (output valid, heater_on, full_mode, on_time_ms, input ready);
    modport sink   (input valid, heater_on, full_mode, on_time_ms, output ready);
endinterface

interface tph_cfg_if;
    logic                                       valid;
    logic                                       ready;
    logic [tph_pkg::TARGET_W-1:0]               target_temp_centi;

    modport source (output valid, target_temp_centi, input ready);
    modport sink   (input valid, target_temp_centi, output ready);
endinterface

// ===== design/tph_in_stage.sv =====
module tph_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    tph_in_if.sink              in_ch,
    input  logic                stall,
    output tph_pkg::tph_stage_t stage
);

    logic               valid_reg;
    logic               valid_next;
    tph_pkg::tph_item_t item_reg;
    logic               load;

    // The stage takes a new word whenever it is empty or its word moves on.
    assign load        = !valid_reg || !stall;
    assign in_ch.ready = load;
    assign valid_next  = load ? in_ch.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_ch.valid)
        begin
            item_reg.now_ms     <= in_ch.now_ms;
            item_reg.temp_centi <= in_ch.temp_centi;
            item_reg.temp_valid <= in_ch.temp_valid;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// ===== design/tph_core.sv =====
module tph_core #(
    parameter int unsigned WINDOW_MS = tph_pkg::WINDOW_MS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tph_pkg::tph_stage_t stage,
    output logic                stall,
    tph_out_if.source           out_ch,
    tph_cfg_if.sink             cfg_ch
);

    localparam int unsigned      OnW   = $clog2(WINDOW_MS + 1);
    localparam tph_pkg::on_tab_t OnTab = tph_pkg::build_on_tab(WINDOW_MS);
    localparam logic [OnW-1:0]   OnFull = OnW'(WINDOW_MS);
    localparam logic [tph_pkg::TIME_W-1:0] WinLen = tph_pkg::TIME_W'(WINDOW_MS);

    // Controller state.
    logic [tph_pkg::TARGET_W-1:0] target_reg;
    logic                         relay_reg, relay_next;
    logic                         full_reg, full_next;
    logic                         inwin_reg, inwin_next;
    logic [tph_pkg::TIME_W-1:0]   win_start_reg, win_start_next;
    logic [tph_pkg::TIME_W-1:0]   sw_on_reg, sw_on_next;

    // Result register.
    logic                         res_valid_reg, res_valid_next;
    logic                         heater_reg;
    logic                         fullm_reg;
    logic [tph_pkg::ON_OUT_W-1:0] on_time_reg;

    logic                               advance;
    logic signed [tph_pkg::ERR_W-1:0]   err;
    logic signed [tph_pkg::ERR_W-1:0]   err_off;
    logic [tph_pkg::ON_IDX_W-1:0]       tab_idx;
    logic [OnW-1:0]                     on_ms;
    logic [tph_pkg::TIME_W-1:0]         now;
    logic [tph_pkg::TIME_W-1:0]         win_elapsed;
    logic [tph_pkg::TIME_W-1:0]         sw_elapsed;
    logic                               win_done;

    assign stall   = res_valid_reg && !out_ch.ready;
    assign advance = stage.valid && !stall;
    assign now     = stage.item.now_ms;

    // Error in hundredths, setpoint minus temperature.
    assign err     = $signed({{(tph_pkg::ERR_W - tph_pkg::TARGET_W){1'b0}}, target_reg})
                   - {{(tph_pkg::ERR_W - tph_pkg::TEMP_W){stage.item.temp_centi[tph_pkg::TEMP_W-1]}},
                      stage.item.temp_centi};
    assign err_off = err - tph_pkg::ERR_PROP_LOW;
    assign tab_idx = err_off[tph_pkg::ON_IDX_W-1:0];

    assign win_elapsed = now - win_start_reg;
    assign win_done    = win_elapsed >= WinLen;

    always_comb
    begin
        relay_next     = relay_reg;
        full_next      = full_reg;
        inwin_next     = inwin_reg;
        win_start_next = win_start_reg;
        sw_on_next     = sw_on_reg;
        on_ms          = '0;
        sw_elapsed     = now - sw_on_reg;

        priority if (!stage.item.temp_valid)
        begin
            // Missing reading: drop the relay, keep the window timing.
            if (relay_reg)
            begin
                relay_next = 1'b0;
                full_next  = 1'b0;
            end
        end
        else if (err <= tph_pkg::ERR_OFF_BAND)
        begin
            if (relay_reg)
            begin
                relay_next = 1'b0;
                inwin_next = 1'b0;
                full_next  = 1'b0;
            end
        end
        else if (err > tph_pkg::ERR_FULL)
        begin
            full_next  = 1'b1;
            relay_next = 1'b1;
        end
        else
        begin
            full_next = 1'b0;
            priority if (err > tph_pkg::ERR_PROP_HIGH)
            begin
                on_ms = OnFull;
            end
            else if (err >= tph_pkg::ERR_PROP_LOW)
            begin
                on_ms = OnW'(OnTab[tab_idx]);
            end
            else if (err > tph_pkg::ERR_ZERO)
            begin
                on_ms = OnW'(OnTab[0]);
            end
            else
            begin
                on_ms = '0;
            end

            if (win_done)
            begin
                win_start_next = now;
                if ((on_ms != '0) && !relay_reg)
                begin
                    relay_next = 1'b1;
                    inwin_next = 1'b1;
                    sw_on_next = now;
                end
            end

            sw_elapsed = now - sw_on_next;
            if (relay_next && inwin_next &&
                (sw_elapsed >= {{(tph_pkg::TIME_W - OnW){1'b0}}, on_ms}))
            begin
                relay_next = 1'b0;
                inwin_next = 1'b0;
            end
        end
    end

    assign res_valid_next = stall ? res_valid_reg : stage.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= tph_pkg::TARGET_RESET;
            relay_reg     <= 1'b0;
            full_reg      <= 1'b0;
            inwin_reg     <= 1'b0;
            win_start_reg <= '0;
            sw_on_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_ch.valid)
            begin
                target_reg <= cfg_ch.target_temp_centi;
            end
            if (advance)
            begin
                relay_reg     <= relay_next;
                full_reg      <= full_next;
                inwin_reg     <= inwin_next;
                win_start_reg <= win_start_next;
                sw_on_reg     <= sw_on_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            heater_reg  <= relay_next;
            fullm_reg   <= full_next;
            on_time_reg <= tph_pkg::ON_OUT_W'(on_ms);
        end
    end

    assign cfg_ch.ready      = 1'b1;
    assign out_ch.valid      = res_valid_reg;
    assign out_ch.heater_on  = heater_reg;
    assign out_ch.full_mode  = fullm_reg;
    assign out_ch.on_time_ms = on_time_reg;

endmodule

// ===== design/time_proportioning_heater_top.sv =====
// Time-proportioning heater controller. Each input word is one control tick
// (timestamp in ms, temperature in hundredths of a degree, reading-valid flag)
// and produces exactly one output word with the relay drive, the full-heating
// flag and the on-time computed for the proportional window. The block takes
// one word per clock cycle while its output is not stalled; an accepted word
// goes first into the input register, then through the decision logic into the
// result register. Throughput is set by the controller state registers, which
// are read and rewritten once per tick in the same cycle. A stalled output
// word holds the result register; the input register still takes one more
// word, and input ready drops only when both are full. The setpoint is written
// through the configuration channel, whose ready is always high; it resets to
// 37.80 degrees and should be changed only while no tick is in flight.
module time_proportioning_heater_top #(
    parameter int unsigned WINDOW_MS = tph_pkg::WINDOW_MS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    tph_in_if.sink     in_ch,
    tph_out_if.source  out_ch,
    tph_cfg_if.sink    cfg_ch
);

    // Word held in the input register, and back-pressure from the result side.
    tph_pkg::tph_stage_t stage;
    logic                stall;

    tph_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .stall (stall),
        .stage (stage)
    );

    // Decision logic, controller state, setpoint and result register.
    tph_core #(
        .WINDOW_MS (WINDOW_MS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .stage  (stage),
        .stall  (stall),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

endmodule

// ===== design/tph_checker.sv =====
module tph_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         heater_on,
    input logic                         full_mode,
    input logic [tph_pkg::ON_OUT_W-1:0] on_time_ms
);

    // A waiting output word keeps its value until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heater_on)
            && $stable(full_mode) && $stable(on_time_ms))
        else $error("output word changed while stalled");

    // Full heating always drives the relay.
    a_full_relay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_mode |-> heater_on)
        else $error("full mode without relay on");

    // Full heating never reports a proportional on-time.
    a_full_no_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_mode |-> on_time_ms == '0)
        else $error("on-time reported in full mode");

    // With no result pending the input side must be open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

endmodule

bind time_proportioning_heater_top tph_checker u_tph_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .heater_on  (out_ch.heater_on),
    .full_mode  (out_ch.full_mode),
    .on_time_ms (out_ch.on_time_ms)
);

// ===== tb/tb_top.sv =====
module tb_top;

    // Window length and decision thresholds of the controller, in ms and in
    // hundredths of a degree. The block is built with its default window.
    localparam int unsigned WINDOW   = tph_pkg::WINDOW_MS_DEF;
    localparam int          OFF_BAND = 15;
    localparam int          FULL_ERR = 200;
    localparam int          PROP_HI  = 80;
    localparam int          PROP_LO  = 30;

    // Cycles without any accepted word before the run is declared hung. The
    // longest correct quiet spell is the receiver hold-off plus the pipeline.
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    // One result word as the output channel carries it.
    typedef struct packed {
        logic                         heater_on;
        logic                         full_mode;
        logic [tph_pkg::ON_OUT_W-1:0] on_time_ms;
    } heater_word_t;

    // The scoreboard keeps its own copy of the controller state and of the
    // setpoint. Every accepted tick is run through it at once, and the word it
    // predicts waits in a queue until the block delivers the matching word.
    class heater_scoreboard;
        bit [tph_pkg::TARGET_W-1:0] setpoint;
        bit                         relay;
        bit                         full;
        bit                         in_window;
        bit [tph_pkg::TIME_W-1:0]   window_start;
        bit [tph_pkg::TIME_W-1:0]   switch_on;
        heater_word_t               pending_words[$];
        int                         errors;

        function new();
            setpoint     = tph_pkg::TARGET_RESET;
            relay        = 1'b0;
            full         = 1'b0;
            in_window    = 1'b0;
            window_start = '0;
            switch_on    = '0;
            errors       = 0;
        endfunction

        function void set_target(bit [tph_pkg::TARGET_W-1:0] value);
            setpoint = value;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void note_tick(tph_pkg::tph_item_t tick);
            int                       temp;
            int                       err;
            int unsigned              on_ms;
            bit [tph_pkg::TIME_W-1:0] since_start;
            bit [tph_pkg::TIME_W-1:0] since_on;
            heater_word_t             word;
            temp  = tick.temp_centi;
            err   = int'(setpoint) - temp;
            on_ms = 0;
            if (!tick.temp_valid)
            begin
                if (relay)
                begin
                    relay = 1'b0;
                    full  = 1'b0;
                end
            end
            else if (temp >= int'(setpoint) - OFF_BAND)
            begin
                if (relay)
                begin
                    relay     = 1'b0;
                    in_window = 1'b0;
                    full      = 1'b0;
                end
            end
            else if (err > FULL_ERR)
            begin
                full  = 1'b1;
                relay = 1'b1;
            end
            else
            begin
                full = 1'b0;
                if (err > PROP_HI)
                    on_ms = WINDOW;
                else if (err >= PROP_LO)
                    on_ms = (WINDOW * (50 + 19 * (err - PROP_LO))) / 1000;
                else if (err > 0)
                    on_ms = (WINDOW * 50) / 1000;
                since_start = tick.now_ms - window_start;
                if (since_start >= WINDOW)
                begin
                    window_start = tick.now_ms;
                    if (on_ms > 0 && !relay)
                    begin
                        relay     = 1'b1;
                        in_window = 1'b1;
                        switch_on = tick.now_ms;
                    end
                end
                since_on = tick.now_ms - switch_on;
                if (relay && in_window && since_on >= on_ms)
                begin
                    relay     = 1'b0;
                    in_window = 1'b0;
                end
            end
            word.heater_on  = relay;
            word.full_mode  = full;
            word.on_time_ms = on_ms[tph_pkg::ON_OUT_W-1:0];
            pending_words.push_back(word);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_word(heater_word_t got);
            heater_word_t want;
            if (pending_words.size() == 0)
            begin
                report($sformatf("word with nothing expected: heater %0d full %0d on %0d",
                                 got.heater_on, got.full_mode, got.on_time_ms));
                return;
            end
            want = pending_words.pop_front();
            if (got.heater_on !== want.heater_on)
                report($sformatf("heater_on %b, expected %b", got.heater_on, want.heater_on));
            if (got.full_mode !== want.full_mode)
                report($sformatf("full_mode %b, expected %b", got.full_mode, want.full_mode));
            if (got.on_time_ms !== want.on_time_ms)
                report($sformatf("on_time_ms %0d, expected %0d",
                                 got.on_time_ms, want.on_time_ms));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;   // when set, neither side inserts random idle cycles

    heater_scoreboard sb;

    tph_in_if  in_ch();
    tph_out_if out_ch();
    tph_cfg_if cfg_ch();

    time_proportioning_heater_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offers one tick and returns at the edge where it is taken. Valid is left
    // high so that back-to-back ticks go out without a bubble; idle cycles are
    // inserted before the word at random unless the steady stretch is on.
    task automatic send_tick(input logic [tph_pkg::TIME_W-1:0] now, input int temp,
                             input logic ok);
        tph_pkg::tph_item_t tick;
        tick.now_ms     = now;
        tick.temp_centi = temp[tph_pkg::TEMP_W-1:0];
        tick.temp_valid = ok;
        while (!steady && $urandom_range(99) < 15)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.now_ms     <= tick.now_ms;
        in_ch.temp_centi <= tick.temp_centi;
        in_ch.temp_valid <= tick.temp_valid;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_tick(tick);
    endtask

    // Stops offering and waits until every predicted word has come back, then
    // lets the two pipeline stages settle before anything else happens.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // The setpoint is only written while nothing is in flight.
    task automatic write_target(input logic [tph_pkg::TARGET_W-1:0] value);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.target_temp_centi <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_target(value);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random ticks shaped like a real controller loop: time mostly moves on by
    // a few seconds so that windows open and close, with the occasional long
    // gap or jump anywhere on the 32-bit clock. Temperatures sit mostly in the
    // proportional band, some in the full-heating region and some anywhere in
    // the 14-bit field; a few readings are flagged missing.
    task automatic random_ticks(input int count, inout logic [tph_pkg::TIME_W-1:0] clock_ms);
        int pick;
        int temp;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                clock_ms = $urandom();
            else if (pick < 15)
                clock_ms += $urandom_range(WINDOW, 3 * WINDOW);
            else
                clock_ms += $urandom_range(0, 4000);
            pick = $urandom_range(99);
            if (pick < 10)
                temp = int'($urandom_range(0, 16383)) - 8192;
            else if (pick < 22)
                temp = int'(sb.setpoint) - int'($urandom_range(190, 400));
            else
                temp = int'(sb.setpoint) - (int'($urandom_range(0, 130)) - 40);
            send_tick(clock_ms, temp, $urandom_range(99) >= 6);
        end
    endtask

    // Main sequence: reset, a directed pass at the reset setpoint, then random
    // phases at several setpoints including both ends of the 12-bit field.
    initial
    begin
        logic [tph_pkg::TIME_W-1:0] clock_ms;
        int                         t;
        sb                       = new();
        rst_n                    <= 1'b0;
        in_ch.valid              <= 1'b0;
        in_ch.now_ms             <= '0;
        in_ch.temp_centi         <= '0;
        in_ch.temp_valid         <= 1'b0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.target_temp_centi <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        t = int'(tph_pkg::TARGET_RESET);
        // Too soon after reset for a window; then the first window opens.
        send_tick(32'd0, t - 100, 1'b1);
        send_tick(32'd20000, t - 100, 1'b1);
        // A missing reading drops the relay but keeps the window running.
        send_tick(32'd25000, t - 50, 1'b0);
        send_tick(32'd30000, t - 50, 1'b1);
        // Shortest on-time: on for 999 ms, off exactly at 1000 ms.
        send_tick(32'd40000, t - 30, 1'b1);
        send_tick(32'd40999, t - 30, 1'b1);
        send_tick(32'd41000, t - 30, 1'b1);
        // Edges of the linear section of the on-time curve.
        send_tick(32'd60000, t - 29, 1'b1);
        send_tick(32'd60500, t - 80, 1'b1);
        send_tick(32'd61000, t - 81, 1'b1);
        // Off band edge: exactly setpoint minus 0.15 switches off, one less does not.
        send_tick(32'd61500, t - 15, 1'b1);
        send_tick(32'd62000, t - 16, 1'b1);
        send_tick(32'd80000, t - 1, 1'b1);
        send_tick(32'd81000, t, 1'b1);
        // Full-heating threshold, then back to the proportional path with the
        // relay still on from full mode but no window open.
        send_tick(32'd82000, t - 200, 1'b1);
        send_tick(32'd83000, t - 201, 1'b1);
        send_tick(32'd84000, t - 250, 1'b1);
        send_tick(32'd85000, t - 100, 1'b1);
        send_tick(32'd86000, t - 100, 1'b0);
        // Field extremes and timestamp wrap.
        send_tick(32'hFFFF_FFFF, -8192, 1'b1);
        send_tick(32'h0000_0010, 8191, 1'b1);
        send_tick(32'hFFFF_F000, t - 60, 1'b1);
        send_tick(32'h0000_1000, t - 60, 1'b1);
        send_tick(32'h0000_5000, t - 60, 1'b1);
        send_tick(32'h0000_6000, -1, 1'b0);
        drain();

        clock_ms = $urandom();
        write_target(12'd3500);
        random_ticks(120, clock_ms);
        drain();

        // No random idling on either side through this phase.
        steady = 1'b1;
        write_target(12'd4000);
        random_ticks(120, clock_ms);
        drain();
        steady = 1'b0;

        write_target(12'd0);
        random_ticks(60, clock_ms);
        drain();

        write_target(12'd4095);
        random_ticks(60, clock_ms);
        drain();

        write_target(tph_pkg::TARGET_W'($urandom_range(3500, 4000)));
        random_ticks(140, clock_ms);
        drain();

        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected words never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: checks every word taken, stalls at random, and after each
    // hundred results, outside the steady stretch, holds ready low for a long
    // stretch so that the block fills both of its registers and has to drop
    // input ready.
    initial
    begin
        int           hold_left;
        int           results_seen;
        int           hold_mark;
        heater_word_t got;
        hold_left    = 0;
        results_seen = 0;
        hold_mark    = 100;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_ch.valid && out_ch.ready)
                begin
                    got.heater_on  = out_ch.heater_on;
                    got.full_mode  = out_ch.full_mode;
                    got.on_time_ms = out_ch.on_time_ms;
                    sb.check_word(got);
                    results_seen++;
                end
                if (hold_left == 0 && !steady && results_seen >= hold_mark)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_mark += 100;
                end
                if (hold_left != 0)
                begin
                    hold_left--;
                    out_ch.ready <= 1'b0;
                end
                else
                    out_ch.ready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    // Watchdog: any handshake on any channel resets the quiet count.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                    (cfg_ch.valid && cfg_ch.ready))
                    quiet = 0;
                else
                    quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
